>>> hdl/pidc_pkg.sv
package pidc_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ErrW    = PosW + 1;
  localparam int unsigned DErrW   = ErrW + 1;
  localparam int unsigned IntegW  = GainW + 1;
  localparam int unsigned SumW    = 52;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [GainW-1:0] PropGainRst    = GainW'(5);
  localparam logic [GainW-1:0] IntegGainRst   = GainW'(3);
  localparam logic [GainW-1:0] DerivGainRst   = GainW'(1);
  localparam logic [GainW-1:0] OutputLimitRst = GainW'(14400);

  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain    = CfgIdxW'(0),
    RegIntegGain   = CfgIdxW'(1),
    RegDerivGain   = CfgIdxW'(2),
    RegOutputLimit = CfgIdxW'(3)
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [GainW-1:0] output_limit;
  } gains_t;

endpackage

>>> hdl/pidc_cfg_regs.sv
module pidc_cfg_regs import pidc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [GainW-1:0]   cfg_data_i,
  output gains_t             gains_o
);

  gains_t gains_q, gains_d;

  always_comb begin
    gains_d = gains_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegPropGain:    gains_d.prop_gain    = cfg_data_i;
        RegIntegGain:   gains_d.integ_gain   = cfg_data_i;
        RegDerivGain:   gains_d.deriv_gain   = cfg_data_i;
        RegOutputLimit: gains_d.output_limit = cfg_data_i;
        default:        gains_d              = gains_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop_gain    <= PropGainRst;
      gains_q.integ_gain   <= IntegGainRst;
      gains_q.deriv_gain   <= DerivGainRst;
      gains_q.output_limit <= OutputLimitRst;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule

>>> hdl/pidc_datapath.sv
module pidc_datapath import pidc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gains_t                 gains_i,
  input  logic signed [PosW-1:0] setpoint_i,
  input  logic signed [PosW-1:0] position_i,
  input  logic                   update_i,
  output logic [GainW-1:0]       duty_o,
  output logic                   reverse_o
);

  logic signed [ErrW-1:0]   last_error_q, last_error_d;
  logic signed [IntegW-1:0] integral_q, integral_d;

  logic signed [ErrW-1:0]  err;
  logic signed [DErrW-1:0] derr;
  logic signed [SumW-1:0]  prop_term, integ_term, deriv_term;
  logic signed [SumW-1:0]  acc, lim_pos, lim_neg, sum;
  logic        [SumW-1:0]  mag;

  always_comb begin
    err  = ErrW'(setpoint_i) - ErrW'(position_i);
    derr = DErrW'(err) - DErrW'(last_error_q);

    // gains are unsigned, so zero-extend into a signed operand
    prop_term  = $signed({1'b0, gains_i.prop_gain}) * err;
    integ_term = $signed({1'b0, gains_i.integ_gain}) * err;
    deriv_term = $signed({1'b0, gains_i.deriv_gain}) * derr;

    lim_pos = $signed({{(SumW-GainW){1'b0}}, gains_i.output_limit});
    lim_neg = -lim_pos;

    acc = SumW'(integral_q) + integ_term;
    if (acc > lim_pos) begin
      acc = lim_pos;
    end
    if (acc < lim_neg) begin
      acc = lim_neg;
    end
    integral_d   = acc[IntegW-1:0];
    last_error_d = err;

    sum       = prop_term + deriv_term + SumW'(integral_d);
    reverse_o = sum[SumW-1];
    mag       = reverse_o ? SumW'(-sum) : SumW'(sum);
    if (mag > SumW'(gains_i.output_limit)) begin
      duty_o = gains_i.output_limit;
    end else begin
      duty_o = mag[GainW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      integral_q   <= '0;
    end else if (update_i) begin
      last_error_q <= last_error_d;
      integral_q   <= integral_d;
    end
  end

endmodule

>>> hdl/pid_position_controller.sv
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i                cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o setpoint_i, position_i
// out       out        out_valid_o / out_stall_i duty_o, reverse_o
//
// One transaction per cycle sustained while out_stall_i is low. An accepted input
// is captured in the input register, which feeds one pass through the three gain
// multipliers, integral clamp and saturation into the result register.
// Reset sets the gains to their defaults and clears the error/integral state.
// A stalled output holds the result register; the input register keeps
// accepting while the result register is free or being drained.
module pid_position_controller import pidc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [GainW-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PosW-1:0] setpoint_i,
  input  logic signed [PosW-1:0] position_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [GainW-1:0]       duty_o,
  output logic                   reverse_o
);

  gains_t gains;

  logic                   s1_valid_q;
  logic signed [PosW-1:0] setpoint_q, position_q;
  logic                   out_valid_q;
  logic [GainW-1:0]       duty_q, duty_d;
  logic                   reverse_q, reverse_d;
  logic                   out_free, advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  pidc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gains_o     (gains)
  );

  pidc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gains_i    (gains),
    .setpoint_i (setpoint_q),
    .position_i (position_q),
    .update_i   (advance),
    .duty_o     (duty_d),
    .reverse_o  (reverse_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      setpoint_q <= setpoint_i;
      position_q <= position_i;
    end
    if (advance) begin
      duty_q    <= duty_d;
      reverse_q <= reverse_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign reverse_o   = reverse_q;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pidc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic [GainW-1:0] duty;
    logic             reverse;
  } drive_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [GainW-1:0]       cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic signed [PosW-1:0] setpoint_i  = '0;
  logic signed [PosW-1:0] position_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [GainW-1:0]       duty_o;
  logic                   reverse_o;

  // mirror of the controller state and gain registers
  gains_t      gains;
  longint      prev_err;
  longint      integ_acc;
  drive_t      drive_q[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;
  int unsigned gap_odds    = 4;

  pid_position_controller dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void pid_reset_model();
    gains.prop_gain    = PropGainRst;
    gains.integ_gain   = IntegGainRst;
    gains.deriv_gain   = DerivGainRst;
    gains.output_limit = OutputLimitRst;
    prev_err  = 0;
    integ_acc = 0;
  endfunction

  // one control step: clamp the integral first, then sum at full precision
  function automatic drive_t pid_predict(logic signed [PosW-1:0] sp,
                                         logic signed [PosW-1:0] pos);
    longint err, lim, acc, sum;
    drive_t d;
    err = longint'(sp) - longint'(pos);
    lim = longint'(gains.output_limit);
    acc = integ_acc + longint'(gains.integ_gain) * err;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ_acc = acc;
    sum = longint'(gains.prop_gain) * err
        + longint'(gains.deriv_gain) * (err - prev_err) + acc;
    prev_err  = err;
    d.reverse = (sum < 0);
    if (sum < 0) sum = -sum;
    d.duty = (sum > lim) ? gains.output_limit : GainW'(sum);
    return d;
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return GainW'($urandom_range(0, 12));
      default: return GainW'($urandom());
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return GainW'(1);
      1: return '1;
      2: return OutputLimitRst;
      default: return GainW'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegPropGain:    gains.prop_gain    = val;
      RegIntegGain:   gains.integ_gain   = val;
      RegDerivGain:   gains.deriv_gain   = val;
      RegOutputLimit: gains.output_limit = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_gains(logic [GainW-1:0] kp, logic [GainW-1:0] ki,
                           logic [GainW-1:0] kd, logic [GainW-1:0] lim);
    write_reg(RegPropGain, kp);
    write_reg(RegIntegGain, ki);
    write_reg(RegDerivGain, kd);
    write_reg(RegOutputLimit, lim);
  endtask

  task automatic write_unmapped();
    write_reg(CfgIdxW'($urandom_range(int'(RegOutputLimit) + 1, (1 << CfgIdxW) - 1)),
              GainW'($urandom()));
  endtask

  // valid stays high on return unless a random gap is inserted, so back-to-back items need no extra edge
  task automatic send_item(logic signed [PosW-1:0] sp, logic signed [PosW-1:0] pos);
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    drive_q.push_back(pid_predict(sp, pos));
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // tracking loop: setpoint drifts, position follows with a small error, with occasional random points
  task automatic send_tracking(int unsigned count);
    logic signed [PosW-1:0] sp;
    int off;
    sp = $urandom();
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: send_item($urandom(), $urandom());
        1: send_item(sp, $urandom());
        default: begin
          sp  = sp + PosW'(int'($urandom_range(0, 64)) - 32);
          off = int'($urandom_range(0, 400)) - 200;
          send_item(sp, sp - PosW'(off));
        end
      endcase
    end
  endtask

  task automatic test_defaults();
    gap_odds = 0;
    send_item(0, 0);
    send_item(10, 0);
    send_item(0, 10);
    send_item(100, 90);
    send_item(-5, -5);
    send_item(32'sh7fff_ffff, 32'sh8000_0000);
    send_item(32'sh8000_0000, 32'sh7fff_ffff);
    send_item(1000, 0);
    send_item(-1000, 0);
    drain();
  endtask

  task automatic test_extreme_gains();
    set_gains('1, '1, '1, '1);
    send_item(32'sh7fff_ffff, 32'sh8000_0000);
    send_item(32'sh8000_0000, 32'sh7fff_ffff);
    send_item(0, 0);
    send_item(1, 0);
    drain();
    // zero limit: duty pinned to 0, direction still follows the sum
    set_gains(GainW'(2), GainW'(1), '0, '0);
    send_item(0, 100);
    send_item(100, 0);
    send_item(0, 0);
    drain();
    // writes past the last register must leave the gains alone
    set_gains(GainW'(3), GainW'(2), GainW'(1), GainW'(500));
    write_unmapped();
    send_item(40, 0);
    drain();
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      set_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit());
      if ($urandom_range(0, 2) == 0) write_unmapped();
      gap_odds = $urandom_range(0, 6);
      send_tracking(210);
      drain();
    end
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    set_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit());
    send_tracking(300);
    drain();
  endtask

  // output backpressure in bursts, with quiet stretches between
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction: duty %0d reverse %0d",
                 $time, duty_o, reverse_o);
      end else begin
        want = drive_q.pop_front();
        if (duty_o !== want.duty) begin
          mismatches++;
          $display("%0t: duty expected %0d actual %0d", $time, want.duty, duty_o);
        end
        if (reverse_o !== want.reverse) begin
          mismatches++;
          $display("%0t: reverse expected %0d actual %0d",
                   $time, want.reverse, reverse_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("pid_position_controller regression: fail");
      $finish;
    end
  end

  initial begin
    pid_reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extreme_gains();
    test_random_settings();
    test_streaming();
    if (mismatches == 0) begin
      $display("pid_position_controller regression: pass");
    end else begin
      $display("pid_position_controller regression: fail");
    end
    $finish;
  end

endmodule

>>> pid_position_controller.f
hdl/pidc_pkg.sv
hdl/pidc_cfg_regs.sv
hdl/pidc_datapath.sv
hdl/pid_position_controller.sv
bench/tb_top.sv
